// ----- sv/icp_pkg.sv -----
package icp_pkg;

    localparam int REF_LEN    = 65536;
    localparam int QRY_LEN    = 65536;
    localparam int COUNT_BITS = 8;
    localparam int ADDR_BITS  = 16;
    localparam int POS_BITS   = 17;
    localparam int HIST_SIZE  = 1 << COUNT_BITS;
    localparam int HIST_BITS  = 17;
    localparam int SUM_BITS   = 25;
    localparam int FIG_BITS   = 17;
    localparam int SPAN_LIMIT = 5;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [0:0] CFG_PCT_FRACTION = 1'd0;
    localparam logic [0:0] CFG_USE_PCT      = 1'd1;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [POS_BITS-1:0] ref_start;
        logic [POS_BITS-1:0] ref_end;
        logic [POS_BITS-1:0] qry_first;
        logic [POS_BITS-1:0] qry_second;
    } t_in_item;

    typedef struct packed {
        logic [FIG_BITS-1:0] ref_coverage;
        logic [FIG_BITS-1:0] qry_coverage;
        logic                ref_is_percentile;
        logic                qry_is_percentile;
        logic                ref_zero_length;
        logic                qry_zero_length;
    } t_out_item;

endpackage

// ----- sv/interval_coverage_percentile_top.sv -----
// channel   direction  handshake                     payload
// in        input      i_in_valid / o_in_ready       icp_pkg::t_in_item
// out       output     o_out_valid / i_out_ready     icp_pkg::t_out_item
// cfg       input      i_cfg_we, i_cfg_index         i_cfg_data (16 bits)
//
// one item at a time; the counter memory port sets the pace
// add: accept, then per span a setup state, a read and a write per walked position and a step
// query: per span setup, a histogram clear, a read, a write and a bin update per walked position,
//   a pick, then a histogram sweep or a restoring division and an emit, and a step
// after reset a clearing pass over all 65536 counter addresses runs before items are taken
// a finished result waits in the output register while the next item enters; the next
//   query result then holds in its last step until that register is free
module interval_coverage_percentile_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  icp_pkg::t_in_item      i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output icp_pkg::t_out_item     o_out_item,
    input  logic                   i_cfg_we,
    input  logic [0:0]             i_cfg_index,
    input  logic [15:0]            i_cfg_data
);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_SETUP  = 4'd2;
    localparam logic [3:0] ST_HCLR   = 4'd3;
    localparam logic [3:0] ST_RD     = 4'd4;
    localparam logic [3:0] ST_WR     = 4'd5;
    localparam logic [3:0] ST_PICK   = 4'd6;
    localparam logic [3:0] ST_SWEEP  = 4'd7;
    localparam logic [3:0] ST_DIV    = 4'd8;
    localparam logic [3:0] ST_NEXT   = 4'd9;
    localparam logic [3:0] ST_EMIT   = 4'd10;
    localparam logic [3:0] ST_HRD    = 4'd11;

    localparam int AB = icp_pkg::ADDR_BITS;
    localparam int PB = icp_pkg::POS_BITS;
    localparam int CB = icp_pkg::COUNT_BITS;
    localparam int HB = icp_pkg::HIST_BITS;
    localparam int SB = icp_pkg::SUM_BITS;
    localparam int FB = icp_pkg::FIG_BITS;
    localparam int QB = SB + 8;         // dividend: sum with 8 fraction bits
    localparam int HA = $clog2(icp_pkg::HIST_SIZE);

    // counter memories, one per coordinate space, and the histogram memory
    logic [CB-1:0] ref_mem [icp_pkg::REF_LEN];
    logic [CB-1:0] qry_mem [icp_pkg::QRY_LEN];
    logic [HB-1:0] hist_mem [icp_pkg::HIST_SIZE];

    logic [3:0]    r_state;
    logic [15:0]   r_pct;
    logic          r_use_pct;
    logic          r_kind;
    logic          r_side;      // 0 reference span, 1 query span
    logic [PB-1:0] r_lo [2];
    logic [PB-1:0] r_hi [2];
    logic [PB-1:0] r_pos;       // also clear and sweep index
    logic [PB-1:0] r_last;
    logic [SB-1:0] r_sum;
    logic [PB-1:0] r_len;
    logic [PB:0]   r_thr;
    logic [HB:0]   r_acc;
    logic [CB-1:0] r_kept;
    logic [CB-1:0] r_rdata;
    logic [HB-1:0] r_hdata;
    logic [PB-1:0] r_rem;
    logic [QB-1:0] r_quo;
    logic [5:0]    r_dcnt;
    logic [FB-1:0] r_fig [2];
    logic          r_pflag [2];
    logic          r_zflag [2];
    logic          r_out_valid;
    icp_pkg::t_out_item r_out;

    logic [AB-1:0] w_addr;
    logic [HA-1:0] w_hidx;
    logic          w_walk;
    logic [PB-1:0] w_qlo, w_qhi;
    logic [PB-1:0] w_a, w_b;
    logic [PB-1:0] w_top;
    logic [PB+16:0] w_prod;
    logic          w_take;
    logic [PB:0]   w_trial;
    logic          w_ge;
    logic          w_emit;

    assign w_addr = AB'(r_pos - PB'(1));
    // the bin of the value just read is fetched while the walk waits on it
    assign w_hidx = (r_state == ST_WR) ? r_rdata : r_pos[HA-1:0];
    assign w_qlo  = (i_in_item.qry_first < i_in_item.qry_second) ?
                    i_in_item.qry_first : i_in_item.qry_second;
    assign w_qhi  = (i_in_item.qry_first < i_in_item.qry_second) ?
                    i_in_item.qry_second : i_in_item.qry_first;
    // clipped walk bounds of the current span
    assign w_top  = r_side ? PB'(icp_pkg::QRY_LEN) : PB'(icp_pkg::REF_LEN);
    assign w_a    = (r_lo[r_side] == '0) ? PB'(1) : r_lo[r_side];
    assign w_b    = (r_hi[r_side] > w_top) ? w_top : r_hi[r_side];
    assign w_walk = (w_b != '0) && (w_a <= w_b);
    assign w_prod = (PB+17)'(r_len) * (PB+17)'(r_pct);

    // percentile sweep: bin present and running count still below threshold
    assign w_take  = (r_hdata != '0) && (r_acc < (HB+1)'(r_thr));
    // restoring divider trial
    assign w_trial = {r_rem, r_quo[QB-1]};
    assign w_ge    = (w_trial >= (PB+1)'(r_len));

    // query result leaves its last step once the output register is free
    assign w_emit = (r_state == ST_NEXT) && r_side && (r_kind == icp_pkg::KIND_QUERY) &&
                    (!r_out_valid || i_out_ready);

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // registered reads of counter and histogram memories
    always_ff @(posedge i_clk) begin
        r_rdata <= r_side ? qry_mem[w_addr] : ref_mem[w_addr];
        r_hdata <= hist_mem[w_hidx];
    end

    // memory writes
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            ref_mem[r_pos[AB-1:0]] <= '0;
            qry_mem[r_pos[AB-1:0]] <= '0;
        end else if (r_state == ST_WR && r_kind == icp_pkg::KIND_ADD) begin
            if (r_rdata != icp_pkg::COUNT_MAX) begin
                if (r_side) qry_mem[w_addr] <= r_rdata + CB'(1);
                else        ref_mem[w_addr] <= r_rdata + CB'(1);
            end
        end
        if (r_state == ST_HCLR) begin
            hist_mem[w_hidx] <= '0;
        end else if (r_state == ST_HRD) begin
            // r_hdata holds the bin of value r_kept, read in the cycle before
            hist_mem[r_kept] <= r_hdata + HB'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_pos       <= '0;
            r_pct       <= 16'd32768;
            r_use_pct   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    icp_pkg::CFG_PCT_FRACTION: r_pct     <= i_cfg_data;
                    icp_pkg::CFG_USE_PCT:      r_use_pct <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_emit) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;

            unique case (r_state)
                ST_CLEAR: begin
                    r_pos <= r_pos + PB'(1);
                    if (r_pos == PB'(icp_pkg::REF_LEN - 1)) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_kind  <= i_in_item.kind;
                        r_lo[0] <= i_in_item.ref_start;
                        r_hi[0] <= i_in_item.ref_end;
                        r_lo[1] <= w_qlo;
                        r_hi[1] <= w_qhi;
                        r_side  <= 1'b0;
                        r_state <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    r_sum   <= '0;
                    r_acc   <= '0;
                    r_kept  <= '0;
                    r_len   <= r_hi[r_side] - r_lo[r_side];
                    if (r_kind == icp_pkg::KIND_ADD) begin
                        r_pos   <= w_a;
                        r_last  <= w_b;
                        r_state <= w_walk ? ST_RD : ST_NEXT;
                    end else if (r_hi[r_side] <= r_lo[r_side]) begin
                        r_fig[r_side]   <= '0;
                        r_pflag[r_side] <= 1'b0;
                        r_zflag[r_side] <= 1'b1;
                        r_state         <= ST_NEXT;
                    end else begin
                        r_pos   <= '0;
                        r_state <= ST_HCLR;
                    end
                end
                ST_HCLR: begin
                    if (r_pos == PB'(icp_pkg::HIST_SIZE - 1)) begin
                        r_pos   <= w_a;
                        r_last  <= w_b;
                        r_thr   <= (PB+1)'(w_prod[PB+16:16]) + (PB+1)'(r_side);
                        r_state <= w_walk ? ST_RD : ST_PICK;
                    end else begin
                        r_pos <= r_pos + PB'(1);
                    end
                end
                ST_RD: begin
                    // counter read issued for position r_pos, at address r_pos - 1
                    r_state <= ST_WR;
                end
                ST_WR: begin
                    if (r_kind == icp_pkg::KIND_ADD) begin
                        if (r_pos == r_last) r_state <= ST_NEXT;
                        else begin
                            r_pos   <= r_pos + PB'(1);
                            r_state <= ST_RD;
                        end
                    end else begin
                        // histogram bin of this value is read this cycle
                        r_sum   <= r_sum + SB'(r_rdata);
                        r_kept  <= r_rdata;
                        r_state <= ST_HRD;
                    end
                end
                ST_HRD: begin
                    // bin written this cycle; resume the walk
                    if (r_pos == r_last) begin
                        r_state <= ST_PICK;
                    end else begin
                        r_pos   <= r_pos + PB'(1);
                        r_state <= ST_RD;
                    end
                end
                ST_PICK: begin
                    r_zflag[r_side] <= 1'b0;
                    r_kept          <= '0;
                    if (r_use_pct && r_len > PB'(icp_pkg::SPAN_LIMIT)) begin
                        r_pos   <= '0;
                        r_dcnt  <= 6'd1;
                        r_state <= ST_SWEEP;
                    end else begin
                        r_rem   <= '0;
                        r_quo   <= {r_sum, 8'd0};
                        r_dcnt  <= 6'd0;
                        r_state <= ST_DIV;
                    end
                end
                ST_SWEEP: begin
                    // r_hdata is the bin at r_pos - 1 (registered read)
                    r_pos  <= r_pos + PB'(1);
                    r_dcnt <= 6'd0;
                    if (r_dcnt == 6'd0 && w_take) begin
                        r_acc  <= r_acc + (HB+1)'(r_hdata);
                        r_kept <= CB'(r_pos - PB'(1));
                    end
                    if (r_pos == PB'(icp_pkg::HIST_SIZE)) begin
                        if (w_take)
                            r_fig[r_side] <= FB'({CB'(r_pos - PB'(1)), 8'd0});
                        else
                            r_fig[r_side] <= FB'({r_kept, 8'd0});
                        r_pflag[r_side] <= 1'b1;
                        r_state         <= ST_NEXT;
                    end
                end
                ST_DIV: begin
                    // restoring division, one quotient bit a cycle
                    if (w_ge) begin
                        r_rem <= PB'(w_trial - (PB+1)'(r_len));
                        r_quo <= {r_quo[QB-2:0], 1'b1};
                    end else begin
                        r_rem <= w_trial[PB-1:0];
                        r_quo <= {r_quo[QB-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'(QB - 1)) r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    r_fig[r_side]   <= r_quo[FB-1:0];
                    r_pflag[r_side] <= 1'b0;
                    r_state         <= ST_NEXT;
                end
                ST_NEXT: begin
                    if (!r_side) begin
                        r_side  <= 1'b1;
                        r_state <= ST_SETUP;
                    end else if (r_kind == icp_pkg::KIND_ADD) begin
                        r_state <= ST_IDLE;
                    end else if (w_emit) begin
                        r_out.ref_coverage      <= r_fig[0];
                        r_out.qry_coverage      <= r_fig[1];
                        r_out.ref_is_percentile <= r_pflag[0];
                        r_out.qry_is_percentile <= r_pflag[1];
                        r_out.ref_zero_length   <= r_zflag[0];
                        r_out.qry_zero_length   <= r_zflag[1];
                        r_state                 <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
